>>> rtl/smallest_primitive_root_assert.svh
// Assertion macros used by the divider RTL
`ifndef SMALLEST_PRIMITIVE_ROOT_ASSERT_SVH
`define SMALLEST_PRIMITIVE_ROOT_ASSERT_SVH

// Property that must hold at every clock edge outside reset
`define SPR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("spr assertion failed");

// Condition that must never be true outside reset
`define SPR_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error("spr forbidden condition");

`endif

>>> rtl/spr_pkg.sv
package spr_pkg;

	localparam int MOD_BITS  = 32;
	localparam int MAX_FAC   = 9;
	localparam int DIV_STEPS = 2 * MOD_BITS;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_F_CHK,
		ST_F_LAUNCH,
		ST_F_DIV,
		ST_F_END,
		ST_CLASSIFY,
		ST_PHI_LAUNCH,
		ST_PHI_DIV,
		ST_PHI_MUL,
		ST_PHI_SET,
		ST_G_NEXT,
		ST_GCD_CHK,
		ST_GCD_LAUNCH,
		ST_GCD_DIV,
		ST_CAND,
		ST_EXP_LAUNCH,
		ST_EXP_DIV,
		ST_PM_LOOP,
		ST_PM_MUL,
		ST_PM_LAUNCH,
		ST_PM_DIV,
		ST_FINISH
	} state_t;

endpackage

>>> rtl/spr_div.sv
module spr_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [spr_pkg::DIV_STEPS-1:0]     dividend,
	input  logic [spr_pkg::MOD_BITS-1:0]      divisor,
	output logic                              done,
	output logic [spr_pkg::DIV_STEPS-1:0]     quotient,
	output logic [spr_pkg::MOD_BITS-1:0]      remainder
);
	`include "smallest_primitive_root_assert.svh"

	localparam int CW = $clog2(spr_pkg::DIV_STEPS + 1);

	logic                              busy_q;
	logic                              done_q;
	logic [CW-1:0]                     cnt_q;
	logic [spr_pkg::DIV_STEPS-1:0]     quo_q;
	logic [spr_pkg::MOD_BITS:0]        rem_q;
	logic [spr_pkg::MOD_BITS-1:0]      div_q;
	logic [spr_pkg::MOD_BITS:0]        trial;
	logic [spr_pkg::MOD_BITS:0]        diff;
	logic                              fits;

	// One restoring step: shift in the next dividend bit and try to subtract
	always_comb begin
		trial = {rem_q[spr_pkg::MOD_BITS-1:0], quo_q[spr_pkg::DIV_STEPS-1]};
		diff  = trial - {1'b0, div_q};
		fits  = (trial >= {1'b0, div_q});
	end

	// Control: busy and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(spr_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load operands, then one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[spr_pkg::DIV_STEPS-2:0], fits};
			rem_q <= fits ? diff : trial;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[spr_pkg::MOD_BITS-1:0];

	`SPR_NEVER(a_start_busy, start && busy_q)
	`SPR_ASSERT(a_start_runs, start |=> busy_q)
	`SPR_ASSERT(a_rem_below, done_q |-> (rem_q < {1'b0, div_q}))

endmodule

>>> rtl/smallest_primitive_root.sv
// Sequencing: moduli 0, 1, 2 and 4 go from idle straight to the finish state, which registers
// out_valid; other moduli take a data dependent time, each division (trial, totient, exponent,
// gcd, modular reduction) holding the shared divider until it finishes.
// Handshake: one modulus at a time, in_ready high only while idle.
// Reset: arst_n asynchronously returns the sequencer to idle and drops out_valid.
module smallest_primitive_root (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [31:0]                   modulus,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          status,
	output logic [31:0]                   root,
	output logic [31:0]                   totient
);

	localparam int W  = spr_pkg::MOD_BITS;
	localparam int FW = $clog2(spr_pkg::MAX_FAC + 1);
	localparam int DW = W / 2 + 1;

	spr_pkg::state_t state_q, state_d;

	logic [W-1:0]   n_q, m_q, phi_q, g_q, ga_q, gb_q, ex_q, r_q, b_q;
	logic [DW-1:0]  d_q;
	logic [W:0]     sq_q;
	logic [5:0]     cnt_q, e0_q;
	logic [FW-1:0]  fac_n_q, i_q;
	logic [W-1:0]   p_q [spr_pkg::MAX_FAC];
	logic           phase_q, tgt_q;
	logic [2*W-1:0] prod_q;
	logic           out_valid_q;
	logic           res_status_q;
	logic [W-1:0]   res_root_q, res_tot_q;

	logic           div_start, div_done;
	logic [2*W-1:0] div_a, div_quo;
	logic [W-1:0]   div_b, div_rem;
	logic [W-1:0]   mul_a, mul_b, p_rd;
	logic           class_ok, special, fac_room;

	spr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_a),
		.divisor   (div_b),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign p_rd     = p_q[i_q];
	assign fac_room = (fac_n_q < FW'(spr_pkg::MAX_FAC));
	assign special  = (modulus == 32'd0) || (modulus == 32'd1) ||
		(modulus == 32'd2) || (modulus == 32'd4);
	assign class_ok = ((fac_n_q == FW'(1)) && (p_q[0] != 32'd2)) ||
		((fac_n_q == FW'(2)) && (p_q[0] == 32'd2) && (e0_q == 6'd1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spr_pkg::ST_IDLE:
				if (in_valid) state_d = special ? spr_pkg::ST_FINISH : spr_pkg::ST_F_CHK;
			spr_pkg::ST_F_CHK:
				state_d = (sq_q > {1'b0, m_q}) ? spr_pkg::ST_F_END : spr_pkg::ST_F_LAUNCH;
			spr_pkg::ST_F_LAUNCH: state_d = spr_pkg::ST_F_DIV;
			spr_pkg::ST_F_DIV:
				if (div_done) begin
					state_d = (div_rem == '0) ? spr_pkg::ST_F_LAUNCH : spr_pkg::ST_F_CHK;
				end
			spr_pkg::ST_F_END:
				state_d = phase_q ? spr_pkg::ST_G_NEXT : spr_pkg::ST_CLASSIFY;
			spr_pkg::ST_CLASSIFY:
				state_d = class_ok ? spr_pkg::ST_PHI_LAUNCH : spr_pkg::ST_FINISH;
			spr_pkg::ST_PHI_LAUNCH: state_d = spr_pkg::ST_PHI_DIV;
			spr_pkg::ST_PHI_DIV: if (div_done) state_d = spr_pkg::ST_PHI_MUL;
			spr_pkg::ST_PHI_MUL: state_d = spr_pkg::ST_PHI_SET;
			spr_pkg::ST_PHI_SET:
				state_d = (i_q + FW'(1) == fac_n_q) ? spr_pkg::ST_F_CHK
					: spr_pkg::ST_PHI_LAUNCH;
			spr_pkg::ST_G_NEXT:
				state_d = (g_q >= n_q) ? spr_pkg::ST_FINISH : spr_pkg::ST_GCD_CHK;
			spr_pkg::ST_GCD_CHK:
				if (gb_q == '0) begin
					state_d = (ga_q == 32'd1) ? spr_pkg::ST_CAND : spr_pkg::ST_G_NEXT;
				end else begin
					state_d = spr_pkg::ST_GCD_LAUNCH;
				end
			spr_pkg::ST_GCD_LAUNCH: state_d = spr_pkg::ST_GCD_DIV;
			spr_pkg::ST_GCD_DIV: if (div_done) state_d = spr_pkg::ST_GCD_CHK;
			spr_pkg::ST_CAND:
				state_d = (i_q == fac_n_q) ? spr_pkg::ST_FINISH : spr_pkg::ST_EXP_LAUNCH;
			spr_pkg::ST_EXP_LAUNCH: state_d = spr_pkg::ST_EXP_DIV;
			spr_pkg::ST_EXP_DIV: if (div_done) state_d = spr_pkg::ST_PM_LOOP;
			spr_pkg::ST_PM_LOOP:
				if (ex_q == '0) begin
					state_d = (r_q == 32'd1) ? spr_pkg::ST_G_NEXT : spr_pkg::ST_CAND;
				end else begin
					state_d = spr_pkg::ST_PM_MUL;
				end
			spr_pkg::ST_PM_MUL: state_d = spr_pkg::ST_PM_LAUNCH;
			spr_pkg::ST_PM_LAUNCH: state_d = spr_pkg::ST_PM_DIV;
			spr_pkg::ST_PM_DIV:
				if (div_done) state_d = tgt_q ? spr_pkg::ST_PM_LOOP : spr_pkg::ST_PM_MUL;
			spr_pkg::ST_FINISH:
				if (!out_valid_q || out_ready) state_d = spr_pkg::ST_IDLE;
			default: state_d = spr_pkg::ST_IDLE;
		endcase
	end

	// Divider and multiplier operand selection
	always_comb begin
		div_start = 1'b0;
		div_a     = '0;
		div_b     = '0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			spr_pkg::ST_F_LAUNCH: begin
				div_start = 1'b1;
				div_a     = {{W{1'b0}}, m_q};
				div_b     = {{(W-DW){1'b0}}, d_q};
			end
			spr_pkg::ST_PHI_LAUNCH, spr_pkg::ST_EXP_LAUNCH: begin
				div_start = 1'b1;
				div_a     = {{W{1'b0}}, phi_q};
				div_b     = p_rd;
			end
			spr_pkg::ST_GCD_LAUNCH: begin
				div_start = 1'b1;
				div_a     = {{W{1'b0}}, ga_q};
				div_b     = gb_q;
			end
			spr_pkg::ST_PM_LAUNCH: begin
				div_start = 1'b1;
				div_a     = prod_q;
				div_b     = n_q;
			end
			spr_pkg::ST_PHI_MUL: begin
				mul_a = phi_q;
				mul_b = p_rd - 32'd1;
			end
			spr_pkg::ST_PM_MUL: begin
				mul_a = tgt_q ? b_q : r_q;
				mul_b = b_q;
			end
			default: ;
		endcase
	end

	// State register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spr_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == spr_pkg::ST_FINISH && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output result registers
	always_ff @(posedge clk) begin
		if (state_q == spr_pkg::ST_FINISH && (!out_valid_q || out_ready)) begin
			status  <= res_status_q;
			root    <= res_root_q;
			totient <= res_tot_q;
		end
	end

	// Product register
	always_ff @(posedge clk) begin
		prod_q <= (2*W)'(mul_a) * (2*W)'(mul_b);
	end

	// Working registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			spr_pkg::ST_IDLE:
				if (in_valid) begin
					n_q          <= modulus;
					m_q          <= modulus;
					d_q          <= DW'(2);
					sq_q         <= (W+1)'(4);
					cnt_q        <= '0;
					fac_n_q      <= '0;
					phase_q      <= 1'b0;
					res_status_q <= 1'b1;
					res_root_q   <= '0;
					res_tot_q    <= '0;
					if (modulus == 32'd1 || modulus == 32'd2 || modulus == 32'd4) begin
						res_status_q <= 1'b0;
						res_root_q   <= modulus - 32'd1;
						res_tot_q    <= (modulus + 32'd1) >> 1;
					end
				end
			spr_pkg::ST_F_DIV:
				if (div_done) begin
					if (div_rem == '0) begin
						m_q   <= div_quo[W-1:0];
						cnt_q <= cnt_q + 6'd1;
					end else begin
						// record the prime just exhausted (if it divided and there is room), then advance the trial divisor
						if (cnt_q != '0 && fac_room) begin
							p_q[fac_n_q] <= {{(W-DW){1'b0}}, d_q};
							if (fac_n_q == '0) e0_q <= cnt_q;
							fac_n_q <= fac_n_q + FW'(1);
						end
						cnt_q <= '0;
						d_q   <= d_q + DW'(1);
						sq_q  <= sq_q + {{(W-DW){1'b0}}, d_q, 1'b0} + (W+1)'(1);
					end
				end
			spr_pkg::ST_F_END: begin
				if (m_q > 32'd1 && fac_room) begin
					p_q[fac_n_q] <= m_q;
					if (fac_n_q == '0) e0_q <= 6'd1;
					fac_n_q <= fac_n_q + FW'(1);
				end
				g_q <= 32'd1;
			end
			spr_pkg::ST_CLASSIFY: begin
				phi_q <= n_q;
				i_q   <= '0;
			end
			spr_pkg::ST_PHI_DIV:
				if (div_done) phi_q <= div_quo[W-1:0];
			spr_pkg::ST_PHI_SET: begin
				phi_q <= prod_q[W-1:0];
				i_q   <= i_q + FW'(1);
				// last prime: start factoring the totient
				if (i_q + FW'(1) == fac_n_q) begin
					m_q     <= prod_q[W-1:0];
					d_q     <= DW'(2);
					sq_q    <= (W+1)'(4);
					cnt_q   <= '0;
					fac_n_q <= '0;
					phase_q <= 1'b1;
				end
			end
			spr_pkg::ST_G_NEXT: begin
				ga_q <= g_q;
				gb_q <= n_q;
			end
			spr_pkg::ST_GCD_CHK:
				if (gb_q == '0) begin
					if (ga_q == 32'd1) i_q <= '0;
					else g_q <= g_q + 32'd1;
				end
			spr_pkg::ST_GCD_DIV:
				if (div_done) begin
					ga_q <= gb_q;
					gb_q <= div_rem;
				end
			spr_pkg::ST_CAND:
				if (i_q == fac_n_q) begin
					res_status_q <= 1'b0;
					res_root_q   <= g_q;
					res_tot_q    <= phi_q;
				end
			spr_pkg::ST_EXP_DIV:
				if (div_done) begin
					ex_q <= div_quo[W-1:0];
					r_q  <= 32'd1;
					b_q  <= g_q;
				end
			spr_pkg::ST_PM_LOOP:
				if (ex_q == '0) begin
					if (r_q == 32'd1) g_q <= g_q + 32'd1;
					else i_q <= i_q + FW'(1);
				end else begin
					tgt_q <= ~ex_q[0];
				end
			spr_pkg::ST_PM_DIV:
				if (div_done) begin
					if (tgt_q) begin
						b_q  <= div_rem;
						ex_q <= ex_q >> 1;
					end else begin
						r_q   <= div_rem;
						tgt_q <= 1'b1;
					end
				end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == spr_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule
